// ----- rtl/i2nf_pkg.sv -----
// ----------------------------------------------------------------------------
// i2nf_pkg - shared definitions for the double to float32 converter
// status codes, field widths and format constants
// ----------------------------------------------------------------------------
package i2nf_pkg;

   localparam int unsigned IN_W   = 64;
   localparam int unsigned WORD_W = 32;
   localparam int unsigned MANT_W = 24;
   localparam int unsigned EXP_W  = 12;
   localparam int unsigned FRAC_W = 52;
   localparam int unsigned BEXP_W = 11;
   localparam int unsigned WIDE_W = 54;

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_INVALID  = 2'd1,
      STATUS_OVERFLOW = 2'd2
   } status_type;

   localparam logic signed [EXP_W-1:0] EXP_MIN  = -12'sd128;
   localparam logic signed [EXP_W-1:0] EXP_MAX  = 12'sd127;
   localparam logic signed [EXP_W-1:0] EXP_BIAS = 12'sd1022;

   localparam logic [BEXP_W-1:0] BEXP_SPECIAL = 11'h7ff;
   localparam logic [BEXP_W-1:0] BEXP_ZERO    = 11'h000;
   localparam logic [BEXP_W:0]   DENORM_BASE  = 12'd894;
   localparam logic [9:0]        SHIFT_ALL    = 10'd53;

   localparam logic [MANT_W-1:0] MANT_NEG_ONE  = 24'h800000;
   localparam logic [MANT_W-1:0] MANT_NEG_HALF = 24'hc00000;
   localparam logic [WORD_W-1:0] WORD_ZERO_VAL = 32'h80000000;
   localparam logic [7:0]        EXP_FIELD_MIN = 8'h80;
   localparam logic [7:0]        EXP_FIELD_MAX = 8'h7f;

   localparam int unsigned HALF_POS = 29;
   localparam int unsigned KEEP_POS = 30;

endpackage

// ----- rtl/ieee_double_to_nec_float32.sv -----
// ----------------------------------------------------------------------------
// ieee_double_to_nec_float32 - binary64 to 8-bit exponent / 24-bit mantissa
// an accepted start is captured in the input regs, then the result regs drive rsp_strobe
// throughput: one word per cycle; busy is never raised
// a result is shown for one cycle only; the receiver cannot stall it
// reset (synchronous, active high) clears both valid flags, no word pending
// ----------------------------------------------------------------------------
module ieee_double_to_nec_float32 (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [i2nf_pkg::IN_W-1:0]           req_ieee_value,
   output logic                                rsp_strobe,
   output logic [i2nf_pkg::WORD_W-1:0]         rsp_target_word,
   output logic [1:0]                          rsp_status
);

   logic                                s1_valid_ff, s1_valid_in;
   logic [i2nf_pkg::IN_W-1:0]           s1_value_ff;
   logic                                out_valid_ff;
   logic [i2nf_pkg::WORD_W-1:0]         word_ff, word_in;
   i2nf_pkg::status_type                status_ff, status_in;

   logic                                sign;
   logic [i2nf_pkg::BEXP_W-1:0]         bexp;
   logic [i2nf_pkg::WIDE_W-1:0]         mag;
   logic [i2nf_pkg::WIDE_W-1:0]         m;
   logic [i2nf_pkg::WIDE_W-1:0]         sum;
   logic signed [i2nf_pkg::EXP_W-1:0]   ex;
   logic [9:0]                          sh;
   logic [i2nf_pkg::MANT_W-1:0]         mant;

   assign busy        = 1'b0;
   assign s1_valid_in = start & ~busy;

   always_comb begin
      sign      = s1_value_ff[63];
      bexp      = s1_value_ff[62:52];
      mag       = {2'b01, s1_value_ff[i2nf_pkg::FRAC_W-1:0]};
      ex        = i2nf_pkg::EXP_W'(signed'({1'b0, bexp}) - i2nf_pkg::EXP_BIAS);
      sh        = '0;
      m         = '0;
      sum       = '0;
      mant      = '0;
      word_in   = '0;
      status_in = i2nf_pkg::STATUS_OK;

      // denormalise down to the smallest exponent
      if (ex < i2nf_pkg::EXP_MIN) begin
         sh = 10'(i2nf_pkg::DENORM_BASE - {1'b0, bexp});
         if (sh >= i2nf_pkg::SHIFT_ALL) begin
            mag = '0;
         end else begin
            mag = mag >> sh[5:0];
         end
         ex = i2nf_pkg::EXP_MIN;
      end

      m = sign ? (~mag + 54'd1) : mag;

      // renormalise when the top two bits agree and the exponent is above the minimum
      if ((m[53] == m[52]) && (ex > i2nf_pkg::EXP_MIN)) begin
         m  = {m[52:0], 1'b0};
         ex = ex - 12'sd1;
      end

      // round half to even at the keep position
      if (m[i2nf_pkg::HALF_POS] &&
          ((|m[i2nf_pkg::HALF_POS-1:0]) || m[i2nf_pkg::KEEP_POS])) begin
         sum = m + (54'd1 << i2nf_pkg::HALF_POS);
         if (!m[53] && sum[53]) begin
            ex  = ex + 12'sd1;
            sum = sum >> 1;
         end
         m = sum;
      end

      mant = m[53:i2nf_pkg::KEEP_POS];

      if (bexp == i2nf_pkg::BEXP_SPECIAL) begin
         word_in   = '0;
         status_in = i2nf_pkg::STATUS_INVALID;
      end else if (bexp == i2nf_pkg::BEXP_ZERO) begin
         word_in   = i2nf_pkg::WORD_ZERO_VAL;
         status_in = i2nf_pkg::STATUS_OK;
      end else if (ex > i2nf_pkg::EXP_MAX) begin
         word_in   = '0;
         status_in = i2nf_pkg::STATUS_OVERFLOW;
      end else begin
         if (mant == '0) begin
            ex = i2nf_pkg::EXP_MIN;
         end
         if ((mant == i2nf_pkg::MANT_NEG_ONE) && (ex < i2nf_pkg::EXP_MAX)) begin
            mant = i2nf_pkg::MANT_NEG_HALF;
            ex   = ex + 12'sd1;
         end
         word_in   = {ex[7:0], mant};
         status_in = i2nf_pkg::STATUS_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_valid_in) begin
         s1_value_ff <= req_ieee_value;
      end
      word_ff   <= word_in;
      status_ff <= status_in;
   end

   assign rsp_strobe      = out_valid_ff;
   assign rsp_target_word = word_ff;
   assign rsp_status      = status_ff;

   a_strobe_follows_start: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start && !busy, 2))
      else $error("result word without an accepted start");

   a_status_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> ((rsp_status == i2nf_pkg::STATUS_OK) ||
                      (rsp_status == i2nf_pkg::STATUS_INVALID) ||
                      (rsp_status == i2nf_pkg::STATUS_OVERFLOW)))
      else $error("illegal status code");

   a_error_word_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && (rsp_status != i2nf_pkg::STATUS_OK)) |-> (rsp_target_word == '0))
      else $error("error status with non-zero word");

   a_zero_mant_min_exp: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && (rsp_status == i2nf_pkg::STATUS_OK) && (rsp_target_word[23:0] == '0))
      |-> (rsp_target_word[31:24] == i2nf_pkg::EXP_FIELD_MIN))
      else $error("zero mantissa without minimum exponent");

   a_neg_one_recoded: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && (rsp_status == i2nf_pkg::STATUS_OK) &&
       (rsp_target_word[23:0] == i2nf_pkg::MANT_NEG_ONE))
      |-> (rsp_target_word[31:24] == i2nf_pkg::EXP_FIELD_MAX))
      else $error("minus one mantissa not recoded");

endmodule
